// File: rtl/cse_pkg.sv
package cse_pkg;

  localparam int unsigned SPECIAL_SLOTS_DEF = 4;
  localparam int unsigned MAX_SLOTS         = 4;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned BUDGET_W          = 16;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned CFG_DATA_W        = 16;
  localparam int unsigned Q_DEPTH           = 2;
  localparam int unsigned Q_PTR_W           = 1;
  localparam int unsigned Q_CNT_W           = 2;

  localparam logic [BYTE_W-1:0]   BACKSLASH   = 8'h5c;
  localparam logic [BYTE_W-1:0]   CHAR_X      = 8'h78;
  localparam logic [BYTE_W-1:0]   CTRL_LIMIT  = 8'd32;
  localparam logic [BYTE_W-1:0]   ASCII_MAX   = 8'h7f;
  localparam logic [BYTE_W-1:0]   HI_MASK     = 8'hf0;
  localparam logic [BYTE_W-1:0]   LO_MASK     = 8'h0f;
  localparam logic [BUDGET_W-1:0] STOP_LEVEL  = 16'd2;
  localparam logic [BUDGET_W-1:0] LIMIT_RESET = 16'hffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_LIMIT   = 3'd0,
    CFG_ESC_HIGH    = 3'd1,
    CFG_SPECIAL_A   = 3'd2,
    CFG_SPECIAL_B   = 3'd3,
    CFG_SPECIAL_C   = 3'd4,
    CFG_SPECIAL_D   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0][BYTE_W-1:0] chars;
    logic [1:0]             last_idx;
    logic                   last;
  } run_t;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] n;
    n = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = 8'(8'h30 + n);
    end else begin
      hex_digit = 8'(8'h57 + n);
    end
  endfunction

  function automatic logic [BYTE_W-1:0] named_escape(input logic [BYTE_W-1:0] b);
    case (b)
      8'h00:   named_escape = 8'h30;
      8'h07:   named_escape = 8'h61;
      8'h08:   named_escape = 8'h62;
      8'h1b:   named_escape = 8'h65;
      8'h0c:   named_escape = 8'h66;
      8'h0a:   named_escape = 8'h6e;
      8'h0d:   named_escape = 8'h72;
      8'h09:   named_escape = 8'h74;
      8'h0b:   named_escape = 8'h76;
      8'h5c:   named_escape = BACKSLASH;
      default: named_escape = 8'h00;
    endcase
  endfunction

endpackage

// File: rtl/cse_in_if.sv
interface cse_in_if;
  import cse_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              last_in;
  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

// File: rtl/cse_out_if.sv
interface cse_out_if;
  import cse_pkg::*;
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   out_char;
  logic                run_last;
  logic                stream_done;
  logic                truncated;
  logic [BUDGET_W-1:0] out_length;
  modport source (output valid, output out_char, output run_last, output stream_done,
                  output truncated, output out_length, input ready);
  modport sink   (input valid, input out_char, input run_last, input stream_done,
                  input truncated, input out_length, output ready);
endinterface

// File: rtl/cse_cfg_if.sv
interface cse_cfg_if;
  import cse_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cse_front.sv
module cse_front
  import cse_pkg::*;
#(
  parameter int unsigned SpecialSlots = SPECIAL_SLOTS_DEF
) (
  cse_in_if.sink           in_i,
  input  logic             esc_high_i,
  input  logic [BYTE_W-1:0] special_i [SpecialSlots],
  input  logic             q_full_i,
  output logic             push_o,
  output run_t             run_o
);

  logic              is_spec;
  logic              is_esc;
  logic [BYTE_W-1:0] b;
  logic [BYTE_W-1:0] named;

  assign b          = in_i.in_byte;
  assign named      = named_escape(b);
  assign in_i.ready = ~q_full_i;
  assign push_o     = in_i.valid & ~q_full_i;

  always_comb begin
    is_spec = 1'b0;
    for (int i = 0; i < SpecialSlots; i++) begin
      if (special_i[i] != '0 && special_i[i] == b) begin
        is_spec = 1'b1;
      end
    end
    if (b == '0) begin
      is_spec = 1'b0;
    end
  end

  assign is_esc = (b < CTRL_LIMIT) || (b == BACKSLASH) || (esc_high_i && b > ASCII_MAX);

  always_comb begin
    run_o.chars    = '0;
    run_o.last_idx = 2'd0;
    run_o.last     = in_i.last_in;
    if (is_spec) begin
      run_o.chars[0] = BACKSLASH;
      run_o.chars[1] = b;
      run_o.last_idx = 2'd1;
    end else if (is_esc) begin
      run_o.chars[0] = BACKSLASH;
      if (named != '0) begin
        run_o.chars[1] = named;
        run_o.last_idx = 2'd1;
      end else begin
        run_o.chars[1] = CHAR_X;
        run_o.chars[2] = hex_digit(4'((b & HI_MASK) >> 4));
        run_o.chars[3] = hex_digit(4'(b & LO_MASK));
        run_o.last_idx = 2'd3;
      end
    end else begin
      run_o.chars[0] = b;
    end
  end

endmodule

// File: rtl/cse_queue.sv
module cse_queue
  import cse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t run_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output run_t head_o
);

  run_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

endmodule

// File: rtl/cse_back.sv
module cse_back
  import cse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [BUDGET_W-1:0] out_limit_i,
  input  logic                empty_i,
  input  run_t                head_i,
  output logic                pop_o,
  cse_out_if.source           out_o
);

  logic [BUDGET_W-1:0] budget_q, budget_d;
  logic [BUDGET_W-1:0] count_q, count_d;
  logic                stopped_q, stopped_d;
  logic [1:0]          k_q, k_d;
  logic                valid_q, valid_d;
  logic [BYTE_W-1:0]   char_q, char_d;
  logic                run_last_q, run_last_d;
  logic                done_q, done_d;
  logic                trunc_q, trunc_d;
  logic [BUDGET_W-1:0] len_q, len_d;
  logic                can_load;
  logic                stop;
  logic                run_end;

  assign can_load = ~valid_q | out_o.ready;
  assign stop     = (budget_q <= STOP_LEVEL);
  assign run_end  = stop || (k_q == head_i.last_idx);

  always_comb begin
    budget_d   = budget_q;
    count_d    = count_q;
    stopped_d  = stopped_q;
    k_d        = k_q;
    pop_o      = 1'b0;
    valid_d    = valid_q & ~out_o.ready;
    char_d     = char_q;
    run_last_d = run_last_q;
    done_d     = done_q;
    trunc_d    = trunc_q;
    len_d      = len_q;
    if (!empty_i) begin
      if (stopped_q) begin
        // drop the rest of the string
        pop_o = 1'b1;
        if (head_i.last) begin
          budget_d  = out_limit_i;
          count_d   = '0;
          stopped_d = 1'b0;
        end
      end else if (can_load) begin
        valid_d    = 1'b1;
        char_d     = head_i.chars[k_q];
        run_last_d = run_end;
        done_d     = stop || (head_i.last && run_end);
        trunc_d    = stop;
        len_d      = count_q + 1'b1;
        count_d    = count_q + 1'b1;
        budget_d   = (budget_q != '0) ? budget_q - 1'b1 : '0;
        if (run_end) begin
          pop_o = 1'b1;
          k_d   = 2'd0;
          if (stop) begin
            stopped_d = 1'b1;
          end
          if (head_i.last) begin
            budget_d  = out_limit_i;
            count_d   = '0;
            stopped_d = 1'b0;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q  <= LIMIT_RESET;
      count_q   <= '0;
      stopped_q <= 1'b0;
      k_q       <= 2'd0;
      valid_q   <= 1'b0;
    end else begin
      budget_q  <= budget_d;
      count_q   <= count_d;
      stopped_q <= stopped_d;
      k_q       <= k_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q     <= char_d;
    run_last_q <= run_last_d;
    done_q     <= done_d;
    trunc_q    <= trunc_d;
    len_q      <= len_d;
  end

  assign out_o.valid       = valid_q;
  assign out_o.out_char    = char_q;
  assign out_o.run_last    = run_last_q;
  assign out_o.stream_done = done_q;
  assign out_o.truncated   = trunc_q;
  assign out_o.out_length  = len_q;

endmodule

// File: rtl/c_string_escape_encoder_unit.sv
// Path: a transferred byte's run is written into the two-entry run queue; the
// single-character emit stage then sends its characters through a registered output,
// one output character per cycle while the receiver is ready. A plain byte gives one
// character, an escape two or four; bytes after truncation are dropped unsent.
// Reset: asynchronous active low; budget 65535, counters clear, config defaults.
module c_string_escape_encoder_unit
  import cse_pkg::*;
#(
  parameter int unsigned SpecialSlots = SPECIAL_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cse_in_if.sink    in_i,
  cse_out_if.source out_o,
  cse_cfg_if.sink   cfg_i
);

  logic [BUDGET_W-1:0] out_limit_q;
  logic                esc_high_q;
  logic [BYTE_W-1:0]   special_q [SpecialSlots];
  logic                cfg_wr;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_empty;
  run_t                run_in;
  run_t                run_head;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= LIMIT_RESET;
      esc_high_q  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_i.index)
        CFG_OUT_LIMIT: out_limit_q <= cfg_i.data;
        CFG_ESC_HIGH:  esc_high_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < SpecialSlots; i++) begin : g_special
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        special_q[i] <= '0;
      end else if (cfg_wr && cfg_i.index == CFG_IDX_W'(CFG_SPECIAL_A + i)) begin
        special_q[i] <= cfg_i.data[BYTE_W-1:0];
      end
    end
  end

  cse_front #(
    .SpecialSlots(SpecialSlots)
  ) u_front (
    .in_i      (in_i),
    .esc_high_i(esc_high_q),
    .special_i (special_q),
    .q_full_i  (q_full),
    .push_o    (push),
    .run_o     (run_in)
  );

  cse_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .run_i  (run_in),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (run_head)
  );

  cse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .out_limit_i(out_limit_q),
    .empty_i    (q_empty),
    .head_i     (run_head),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

// File: sim/cse_escape_checker.sv
`timescale 1ns / 100ps

module cse_escape_checker
  import cse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cse_in_if    in_mon,
  cse_out_if   out_mon,
  cse_cfg_if   cfg_mon,
  output int   err_count_o,
  output int   pending_o,
  output int   bytes_seen_o,
  output int   chars_seen_o,
  output int   cut_count_o
);

  typedef struct packed {
    logic [BYTE_W-1:0]   ch;
    logic                run_end;
    logic                done;
    logic                cut;
    logic [BUDGET_W-1:0] length;
  } esc_char_t;

  localparam logic [8*16-1:0] HEX_DIGITS = "0123456789abcdef";

  logic [BUDGET_W-1:0] limit_q;
  logic [BUDGET_W-1:0] budget_q;
  logic [BUDGET_W-1:0] emitted_q;
  logic                high_esc_q;
  logic                halted_q;
  logic [BYTE_W-1:0]   special_q [MAX_SLOTS];

  esc_char_t expected_chars [$];

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    hex_char = HEX_DIGITS[8*(15-nib) +: 8];
  endfunction

  function automatic logic [BYTE_W-1:0] escape_letter(input logic [BYTE_W-1:0] b);
    case (b)
      8'h00:     escape_letter = "0";
      8'h07:     escape_letter = "a";
      8'h08:     escape_letter = "b";
      8'h09:     escape_letter = "t";
      8'h0a:     escape_letter = "n";
      8'h0b:     escape_letter = "v";
      8'h0c:     escape_letter = "f";
      8'h0d:     escape_letter = "r";
      8'h1b:     escape_letter = "e";
      BACKSLASH: escape_letter = BACKSLASH;
      default:   escape_letter = 8'h00;
    endcase
  endfunction

  function automatic int build_run(input logic [BYTE_W-1:0] b,
                                   output logic [3:0][BYTE_W-1:0] run);
    logic [BYTE_W-1:0] letter;
    logic              hit;
    hit = 1'b0;
    run = '0;
    for (int i = 0; i < SPECIAL_SLOTS_DEF && i < MAX_SLOTS; i++) begin
      if (b != 8'h00 && special_q[i] != 8'h00 && special_q[i] == b) hit = 1'b1;
    end
    if (hit) begin
      run[0] = BACKSLASH;
      run[1] = b;
      return 2;
    end
    if (b < CTRL_LIMIT || b == BACKSLASH || (high_esc_q && b > ASCII_MAX)) begin
      letter = escape_letter(b);
      run[0] = BACKSLASH;
      if (letter != 8'h00) begin
        run[1] = letter;
        return 2;
      end
      run[1] = CHAR_X;
      run[2] = hex_char(b[7:4]);
      run[3] = hex_char(b[3:0]);
      return 4;
    end
    run[0] = b;
    return 1;
  endfunction

  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic fin);
    logic [3:0][BYTE_W-1:0] run;
    int                     n;
    logic                   stop;
    logic                   run_end;
    esc_char_t              e;
    if (!halted_q) begin
      n = build_run(b, run);
      for (int k = 0; k < n; k++) begin
        stop      = budget_q <= STOP_LEVEL;
        run_end   = stop || (k == n - 1);
        budget_q  = (budget_q != '0) ? budget_q - 1'b1 : '0;
        emitted_q = emitted_q + 1'b1;
        e.ch      = run[k];
        e.run_end = run_end;
        e.done    = stop || (fin && run_end);
        e.cut     = stop;
        e.length  = emitted_q;
        expected_chars.push_back(e);
        if (stop) begin
          halted_q = 1'b1;
          break;
        end
      end
    end
    if (fin) begin
      budget_q  = limit_q;
      halted_q  = 1'b0;
      emitted_q = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint exp, input longint got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h (character %0d)",
             what, exp, got, chars_seen_o);
    err_count_o++;
  endtask

  task automatic check_char();
    esc_char_t e;
    if (expected_chars.size() == 0) begin
      flag_mismatch("unexpected character", 0, out_mon.out_char);
      return;
    end
    e = expected_chars.pop_front();
    if (out_mon.out_char !== e.ch)         flag_mismatch("out_char", e.ch, out_mon.out_char);
    if (out_mon.run_last !== e.run_end)    flag_mismatch("run_last", e.run_end, out_mon.run_last);
    if (out_mon.stream_done !== e.done)    flag_mismatch("stream_done", e.done,
                                                         out_mon.stream_done);
    if (out_mon.truncated !== e.cut)       flag_mismatch("truncated", e.cut, out_mon.truncated);
    if (out_mon.out_length !== e.length)   flag_mismatch("out_length", e.length,
                                                         out_mon.out_length);
    if (e.cut) cut_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      = LIMIT_RESET;
      budget_q     = LIMIT_RESET;
      emitted_q    = '0;
      high_esc_q   = 1'b0;
      halted_q     = 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) special_q[i] = '0;
      expected_chars.delete();
      err_count_o  = 0;
      pending_o    = 0;
      bytes_seen_o = 0;
      chars_seen_o = 0;
      cut_count_o  = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CFG_OUT_LIMIT: limit_q      = cfg_mon.data[BUDGET_W-1:0];
          CFG_ESC_HIGH:  high_esc_q   = cfg_mon.data[0];
          CFG_SPECIAL_A: special_q[0] = cfg_mon.data[BYTE_W-1:0];
          CFG_SPECIAL_B: special_q[1] = cfg_mon.data[BYTE_W-1:0];
          CFG_SPECIAL_C: special_q[2] = cfg_mon.data[BYTE_W-1:0];
          CFG_SPECIAL_D: special_q[3] = cfg_mon.data[BYTE_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        check_char();
        chars_seen_o++;
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_byte(in_mon.in_byte, in_mon.last_in);
        bytes_seen_o++;
      end
      pending_o = expected_chars.size();
    end
  end

endmodule

// File: sim/c_string_escape_encoder_unit_tb.sv
`timescale 1ns / 100ps

module c_string_escape_encoder_unit_tb;
  import cse_pkg::*;

  logic clk;
  logic rst_n;

  cse_in_if  byte_ch ();
  cse_out_if char_ch ();
  cse_cfg_if cfg_ch ();

  int err_cnt;
  int pending_cnt;
  int bytes_cnt;
  int chars_cnt;
  int cut_cnt;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_trigger   = 1'b0;
  bit hold_on        = 1'b0;

  logic [BYTE_W-1:0] spec_pick [MAX_SLOTS];

  c_string_escape_encoder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (char_ch),
    .cfg_i  (cfg_ch)
  );

  cse_escape_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (byte_ch),
    .out_mon      (char_ch),
    .cfg_mon      (cfg_ch),
    .err_count_o  (err_cnt),
    .pending_o    (pending_cnt),
    .bytes_seen_o (bytes_cnt),
    .chars_seen_o (chars_cnt),
    .cut_count_o  (cut_cnt)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    char_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      char_ch.ready <= !hold_on && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // long receiver hold-off so the run queue fills and the input stalls
  initial begin
    wait (hold_trigger);
    hold_on = 1'b1;
    repeat (300) @(posedge clk);
    hold_on = 1'b0;
  end

  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    byte_ch.last_in <= fin;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic end_burst();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [BUDGET_W-1:0] limit, input logic high,
                            input logic [BYTE_W-1:0] sa, input logic [BYTE_W-1:0] sb,
                            input logic [BYTE_W-1:0] sc, input logic [BYTE_W-1:0] sd);
    drain();
    write_reg(CFG_OUT_LIMIT, limit);
    write_reg(CFG_ESC_HIGH, {15'd0, high});
    write_reg(CFG_SPECIAL_A, {8'd0, sa});
    write_reg(CFG_SPECIAL_B, {8'd0, sb});
    write_reg(CFG_SPECIAL_C, {8'd0, sc});
    write_reg(CFG_SPECIAL_D, {8'd0, sd});
    spec_pick[0] = sa;
    spec_pick[1] = sb;
    spec_pick[2] = sc;
    spec_pick[3] = sd;
  endtask

  function automatic logic [BUDGET_W-1:0] rand_limit();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'hffff;
      4:       return 16'($urandom_range(65535));
      default: return 16'($urandom_range(3, 60));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] rand_special();
    case ($urandom_range(7))
      0, 1:    return 8'h00;
      2:       return 8'hff;
      3:       return BACKSLASH;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0, 1, 2: return 8'($urandom_range(8'h20, 8'h7e));
      3, 4:    return 8'($urandom_range(0, 8'h1f));
      5:       return BACKSLASH;
      6:       return spec_pick[$urandom_range(MAX_SLOTS - 1)];
      7:       return 8'($urandom_range(8'h80, 8'hff));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic run_strings(input int n, input int pause_at);
    int count;
    int len;
    count = 0;
    while (count < n) begin
      len = $urandom_range(1, 10);
      for (int k = 0; k < len && count < n; k++) begin
        if (count == pause_at) begin
          byte_ch.valid <= 1'b0;
          drain();
        end
        send_byte(pick_byte(), k == len - 1);
        count++;
      end
    end
    end_burst();
  endtask

  initial begin
    logic [BYTE_W-1:0] probe [15];
    int                src_tab  [4];
    int                sink_tab [4];
    probe = '{8'h00, 8'h07, 8'h08, 8'h1b, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b,
              8'h5c, 8'h01, 8'h20, 8'h7f, 8'h80, 8'hff};
    src_tab  = '{0, 71, 0, 29};
    sink_tab = '{0, 0, 71, 29};
    for (int i = 0; i < MAX_SLOTS; i++) spec_pick[i] = '0;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = '0;
    byte_ch.last_in = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    rst_n           = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 15; i++) send_byte(probe[i], i == 14);
    end_burst();

    // specials win over named and high-bit escapes; new budget waits for next string
    set_config(16'd3, 1'b1, 8'h22, 8'h80, 8'h0a, 8'h00);
    send_byte(8'h22, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h0a, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h43, 1'b1);
    send_byte(8'h22, 1'b1);
    end_burst();
    drain();
    write_reg(CFG_OUT_LIMIT, 16'd0);
    send_byte(8'h5c, 1'b1);
    send_byte(8'h41, 1'b1);
    end_burst();
    drain();
    write_reg(CFG_OUT_LIMIT, 16'hffff);
    send_byte(8'h0a, 1'b1);
    end_burst();

    for (int ph = 0; ph < 8; ph++) begin
      set_config(rand_limit(), 1'($urandom_range(1)), rand_special(), rand_special(),
                 rand_special(), rand_special());
      src_idle_pct   = src_tab[ph % 4];
      sink_stall_pct = sink_tab[ph % 4];
      if (ph == 4) hold_trigger = 1'b1;
      run_strings(45, (ph == 5) ? 20 : -1);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Summary: %0d bytes in, %0d characters checked, %0d truncated strings",
             bytes_cnt, chars_cnt, cut_cnt);
    $display("Covered named, hex, special and plain escapes under tight budgets, ",
             "with gaps, stalls and a long hold-off");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/cse_pkg.sv
rtl/cse_in_if.sv
rtl/cse_out_if.sv
rtl/cse_cfg_if.sv
rtl/cse_front.sv
rtl/cse_queue.sv
rtl/cse_back.sv
rtl/c_string_escape_encoder_unit.sv
sim/cse_escape_checker.sv
sim/c_string_escape_encoder_unit_tb.sv
